/* hdl/ppr_pkg.sv */
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int unsigned COUNT_BITS_DEF  = 24;
    localparam int unsigned IDLE_PERIOD_DEF = 65535;
    localparam int unsigned LIMIT_BITS      = 8;

    localparam logic [LIMIT_BITS-1:0] SLEEP_LIMIT_RST = 8'd100;
    localparam logic [LIMIT_BITS-1:0] IDLE_COUNT_MAX  = 8'd255;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    typedef struct packed {
        logic fire;
        logic kind;
        logic switch_high;
    } t_ppr_event;

    typedef struct packed {
        logic drive_level;
        logic status_level;
    } t_ppr_levels;

endpackage

/* hdl/ppr_core.sv */
`timescale 1ns / 1ps

module ppr_core #(
    parameter int unsigned COUNT_BITS  = ppr_pkg::COUNT_BITS_DEF,
    parameter int unsigned IDLE_PERIOD = ppr_pkg::IDLE_PERIOD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppr_pkg::t_ppr_event             i_event,
    input  logic [ppr_pkg::LIMIT_BITS-1:0]  i_sleep_limit,
    output ppr_pkg::t_ppr_levels            o_next_levels
);

    localparam longint unsigned CountMax = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint unsigned IdleLoad =
        (64'(IDLE_PERIOD) > CountMax) ? CountMax : 64'(IDLE_PERIOD);
    localparam longint unsigned IdleQuot = (IdleLoad * 4) / 5;
    localparam longint unsigned IdleRem  = (IdleLoad * 4) % 5;
    localparam logic [COUNT_BITS-1:0] IDLE_VAL  = IdleLoad[COUNT_BITS-1:0];
    localparam logic [COUNT_BITS-1:0] IDLE_QUOT = IdleQuot[COUNT_BITS-1:0];
    localparam logic [2:0]            IDLE_REM  = IdleRem[2:0];

    // The scaled value floor(period_count * 4 / 5) is tracked alongside the
    // count as a quotient and remainder, so an edge needs no divider.
    logic [COUNT_BITS-1:0]          r_period, n_period;
    logic [COUNT_BITS-1:0]          r_quot, n_quot;
    logic [2:0]                     r_rem, n_rem;
    logic [COUNT_BITS-1:0]          r_interval, n_interval;
    logic [COUNT_BITS-1:0]          r_limit, n_limit;
    logic [ppr_pkg::LIMIT_BITS-1:0] r_idle, n_idle;
    logic                           r_seen, n_seen;
    logic                           r_asleep, n_asleep;
    logic                           r_drive, n_drive;
    logic                           r_status, n_status;
    logic [COUNT_BITS-1:0]          w_interval_inc;

    always_comb begin
        n_period   = r_period;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_interval = r_interval;
        n_limit    = r_limit;
        n_idle     = r_idle;
        n_seen     = r_seen;
        n_asleep   = r_asleep;
        n_drive    = r_drive;
        n_status   = r_status;
        w_interval_inc = (&r_interval) ? r_interval : r_interval + 1'b1;

        if (i_event.fire) begin
            if (i_event.kind == ppr_pkg::KIND_EDGE) begin
                n_limit  = i_event.switch_high ? r_quot : {1'b0, r_period[COUNT_BITS-1:1]};
                n_period = '0;
                n_quot   = '0;
                n_rem    = '0;
                if (r_asleep) begin
                    n_asleep   = 1'b0;
                    n_status   = 1'b1;
                    n_interval = '0;
                    n_idle     = '0;
                    n_seen     = 1'b0;
                end else begin
                    n_seen = 1'b1;
                end
            end else if (!r_asleep) begin
                if (!(&r_period)) begin
                    n_period = r_period + 1'b1;
                    if (r_rem == 3'd0) begin
                        n_rem = 3'd4;
                    end else begin
                        n_quot = r_quot + 1'b1;
                        n_rem  = r_rem - 3'd1;
                    end
                end
                n_interval = w_interval_inc;
                if (w_interval_inc >= r_limit) begin
                    if (!r_seen && (r_idle > i_sleep_limit)) begin
                        n_status   = 1'b0;
                        n_drive    = 1'b1;
                        n_period   = IDLE_VAL;
                        n_quot     = IDLE_QUOT;
                        n_rem      = IDLE_REM;
                        n_interval = IDLE_VAL;
                        n_limit    = IDLE_VAL;
                        n_idle     = '0;
                        n_asleep   = 1'b1;
                    end else begin
                        if (r_seen) begin
                            n_idle = '0;
                        end else if (r_idle != ppr_pkg::IDLE_COUNT_MAX) begin
                            n_idle = r_idle + 1'b1;
                        end
                        n_interval = '0;
                        n_drive    = ~r_drive;
                        n_seen     = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= '0;
            r_quot     <= '0;
            r_rem      <= '0;
            r_interval <= '0;
            r_limit    <= IDLE_VAL;
            r_idle     <= '0;
            r_seen     <= 1'b0;
            r_asleep   <= 1'b0;
            r_drive    <= 1'b1;
            r_status   <= 1'b1;
        end else begin
            r_period   <= n_period;
            r_quot     <= n_quot;
            r_rem      <= n_rem;
            r_interval <= n_interval;
            r_limit    <= n_limit;
            r_idle     <= n_idle;
            r_seen     <= n_seen;
            r_asleep   <= n_asleep;
            r_drive    <= n_drive;
            r_status   <= n_status;
        end
    end

    assign o_next_levels.drive_level  = n_drive;
    assign o_next_levels.status_level = n_status;

endmodule

/* hdl/pulse_period_rescaler.sv */
`timescale 1ns / 1ps

// Pulse period rescaler. Each input transaction is either a time tick or a
// falling edge on the speed input, and each one produces exactly one output
// transaction carrying the drive and status levels after it is applied. The
// block takes one transaction every clock cycle while the output side does not
// stall; a transaction passes an input register and a result register before
// its result is presented on the output, where it is taken at a clock edge
// when the output side does not stall. The scaled period is kept up to date as
// the count runs, so an edge costs no more than a tick.
// The sleep limit register may be written at any time the block is idle.

module pulse_period_rescaler #(
    parameter int unsigned COUNT_BITS  = ppr_pkg::COUNT_BITS_DEF,
    parameter int unsigned IDLE_PERIOD = ppr_pkg::IDLE_PERIOD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic                           i_switch_high,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_drive_level,
    output logic                           o_status_level,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppr_pkg::LIMIT_BITS-1:0] i_cfg_data
);

    logic                           r_in_valid;
    logic                           r_kind;
    logic                           r_switch_high;
    logic                           r_out_valid;
    logic                           r_drive;
    logic                           r_status;
    logic [ppr_pkg::LIMIT_BITS-1:0] r_sleep_limit;
    logic                           w_out_free;
    logic                           w_fire;
    logic                           w_in_accept;
    ppr_pkg::t_ppr_event            w_event;
    ppr_pkg::t_ppr_levels           w_levels;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_event.fire        = w_fire;
    assign w_event.kind        = r_kind;
    assign w_event.switch_high = r_switch_high;

    ppr_core #(
        .COUNT_BITS  (COUNT_BITS),
        .IDLE_PERIOD (IDLE_PERIOD)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_event       (w_event),
        .i_sleep_limit (r_sleep_limit),
        .o_next_levels (w_levels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_sleep_limit <= ppr_pkg::SLEEP_LIMIT_RST;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_sleep_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_kind        <= i_kind;
            r_switch_high <= i_switch_high;
        end
        if (w_fire) begin
            r_drive  <= w_levels.drive_level;
            r_status <= w_levels.status_level;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_level  = r_drive;
    assign o_status_level = r_status;

endmodule

/* hdl/ppr_checker.sv */
`timescale 1ns / 1ps

module ppr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_drive_level,
    input logic o_status_level,
    input logic o_cfg_ready
);

    // While asleep the drive output rests at its idle level.
    a_sleep_drive_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status_level |-> o_drive_level)
        else $error("drive level low while asleep");

    // Input backpressure only comes from a held result that is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // A stalled result transaction holds its levels.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive_level)
            && $stable(o_status_level))
        else $error("stalled result changed");

    // No result is pending directly after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result pending after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind pulse_period_rescaler ppr_checker u_ppr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_drive_level  (o_drive_level),
    .o_status_level (o_status_level),
    .o_cfg_ready    (o_cfg_ready)
);

/* tb/sv/tb_pulse_period_rescaler.sv */
`timescale 1ns / 1ps

module tb_pulse_period_rescaler;
    import ppr_pkg::*;

    localparam int unsigned COUNT_W = COUNT_BITS_DEF;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned IDLE_SAT =
        (longint'(IDLE_PERIOD_DEF) > COUNT_MAX) ? COUNT_MAX : longint'(IDLE_PERIOD_DEF);
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 8;

    class level_tracker;
        logic [COUNT_W-1:0]    period_cnt;
        logic [COUNT_W-1:0]    interval_cnt;
        logic [COUNT_W-1:0]    interval_lim;
        logic [LIMIT_BITS-1:0] idle_cnt;
        logic [LIMIT_BITS-1:0] sleep_lim;
        logic                  edge_flag;
        logic                  sleeping;
        logic                  drive;
        logic                  status;
        t_ppr_levels           levels_due[$];
        int                    errors;
        int                    checked;
        int                    toggles;
        int                    sleeps;
        int                    wakes;

        function new();
            sleep_lim    = SLEEP_LIMIT_RST;
            period_cnt   = '0;
            interval_cnt = '0;
            interval_lim = COUNT_W'(IDLE_SAT);
            idle_cnt     = '0;
            edge_flag    = 1'b0;
            sleeping     = 1'b0;
            drive        = 1'b1;
            status       = 1'b1;
            errors       = 0;
            checked      = 0;
            toggles      = 0;
            sleeps       = 0;
            wakes        = 0;
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
            return (v == COUNT_W'(COUNT_MAX)) ? v : v + 1'b1;
        endfunction

        function logic [COUNT_W-1:0] scaled(logic [COUNT_W-1:0] cnt, logic sw);
            logic [COUNT_W+3:0] wide;
            wide = {4'b0000, cnt};
            if (sw) begin
                wide = (wide << 3) / 10;
            end else begin
                wide = wide >> 1;
            end
            return wide[COUNT_W-1:0];
        endfunction

        function void set_limit(logic [LIMIT_BITS-1:0] v);
            sleep_lim = v;
        endfunction

        function void note_event(logic kind, logic sw);
            t_ppr_levels lv;
            if (kind == KIND_EDGE) begin
                interval_lim = scaled(period_cnt, sw);
                period_cnt   = '0;
                if (sleeping) begin
                    sleeping     = 1'b0;
                    status       = 1'b1;
                    interval_cnt = '0;
                    idle_cnt     = '0;
                    edge_flag    = 1'b0;
                    wakes++;
                end else begin
                    edge_flag = 1'b1;
                end
            end else if (!sleeping) begin
                period_cnt   = bump(period_cnt);
                interval_cnt = bump(interval_cnt);
                if (interval_cnt >= interval_lim) begin
                    if (!edge_flag && idle_cnt > sleep_lim) begin
                        status       = 1'b0;
                        drive        = 1'b1;
                        period_cnt   = COUNT_W'(IDLE_SAT);
                        interval_cnt = COUNT_W'(IDLE_SAT);
                        interval_lim = COUNT_W'(IDLE_SAT);
                        idle_cnt     = '0;
                        sleeping     = 1'b1;
                        sleeps++;
                    end else begin
                        if (edge_flag) begin
                            idle_cnt = '0;
                        end else if (idle_cnt != IDLE_COUNT_MAX) begin
                            idle_cnt = idle_cnt + 1'b1;
                        end
                        interval_cnt = '0;
                        drive        = ~drive;
                        edge_flag    = 1'b0;
                        toggles++;
                    end
                end
            end
            lv.drive_level  = drive;
            lv.status_level = status;
            levels_due.push_back(lv);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_levels(logic drive_got, logic status_got);
            t_ppr_levels want;
            if (levels_due.size() == 0) begin
                report("output transaction with no pending input transaction");
            end else begin
                want = levels_due.pop_front();
                checked++;
                if (drive_got !== want.drive_level) begin
                    report($sformatf("drive_level got %b expected %b",
                                     drive_got, want.drive_level));
                end
                if (status_got !== want.status_level) begin
                    report($sformatf("status_level got %b expected %b",
                                     status_got, want.status_level));
                end
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_kind;
    logic                  i_switch_high;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_drive_level;
    logic                  o_status_level;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [LIMIT_BITS-1:0] i_cfg_data;

    level_tracker tracker;
    bit           hold_req = 1'b0;
    bit           quiet = 1'b0;
    int           n_sent = 0;
    int           n_edges = 0;
    int           n_cfg = 0;
    int unsigned  idle_cycles = 0;

    pulse_period_rescaler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_switch_high  (i_switch_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_level  (o_drive_level),
        .o_status_level (o_status_level),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_levels(o_drive_level, o_status_level);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_pulse_period_rescaler failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The output side stalls in random bursts, with occasional clean stretches,
    // and honors one long hold request while the input side keeps sending.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 39) == 0) begin
                repeat ($urandom_range(50, 150)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic kind, input logic sw);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_switch_high <= sw;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_event(kind, sw);
        n_sent++;
        if (kind == KIND_EDGE) begin
            n_edges++;
        end
    endtask

    task automatic push(input logic kind, input logic sw);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        send_item(kind, sw);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) push(KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.levels_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_limit(v);
        n_cfg++;
    endtask

    // Mostly regular edge trains with random spacing; long tick runs let the
    // pulse generator go to sleep, and a few stray transactions add noise.
    task automatic random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            run_ticks($urandom_range(0, 16));
            push(KIND_EDGE, 1'($urandom_range(0, 1)));
        end else if (r < 85) begin
            run_ticks($urandom_range(20, 120));
            push(KIND_EDGE, 1'($urandom_range(0, 1)));
        end else if (r < 95) begin
            repeat ($urandom_range(1, 6)) begin
                push(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end else begin
            push(KIND_EDGE, 1'($urandom_range(0, 1)));
            push(KIND_EDGE, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int items);
        int stop;
        stop = n_sent + items;
        while (n_sent < stop) random_sequence();
    endtask

    task automatic directed();
        push(KIND_TICK, 1'b0);
        push(KIND_TICK, 1'b1);
        push(KIND_EDGE, 1'b1);
        push(KIND_TICK, 1'b0);
        push(KIND_TICK, 1'b1);
        push(KIND_EDGE, 1'b0);
        push(KIND_EDGE, 1'b0);
        run_ticks(3);
        write_limit(8'd0);
        run_ticks(4);
        push(KIND_EDGE, 1'b0);
        run_ticks(8);
        push(KIND_EDGE, 1'b1);
        push(KIND_EDGE, 1'b0);
    endtask

    initial begin
        tracker = new();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_TICK;
        i_switch_high <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        write_limit(8'd0);
        hold_req = 1'b1;
        run_random(220);
        write_limit(8'd255);
        run_random(220);
        write_limit(8'd1);
        run_random(110);
        drain();
        run_random(110);
        write_limit(8'd3);
        run_random(220);
        write_limit(LIMIT_BITS'($urandom_range(0, 255)));
        run_random(220);
        write_limit(LIMIT_BITS'($urandom_range(0, 7)));
        run_random(220);
        quiet = 1'b1;
        write_limit(8'd2);
        run_random(200);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions (%0d edges) over %0d sleep-limit settings.",
                 n_sent, n_edges, n_cfg);
        $display("Checked %0d results through %0d toggles, %0d sleeps and %0d wakes.",
                 tracker.checked, tracker.toggles, tracker.sleeps, tracker.wakes);
        if (tracker.errors == 0 && tracker.levels_due.size() == 0) begin
            $display("tb_pulse_period_rescaler passed");
        end else begin
            $display("tb_pulse_period_rescaler failed");
        end
        $finish;
    end

endmodule
